[rtl/core/sitd_pkg.sv]
// ----------------------------------------------------------------------------
// sitd_pkg
// Shared types and constants for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
package sitd_pkg;

	// default input width
	localparam int VALUE_BITS_DEF = 32;

	// one decimal digit in bcd
	localparam int DIGIT_W = 4;

	// a bcd digit at or above this value gets the add-3 correction
	localparam logic [DIGIT_W-1:0] BCD_LIMIT = 4'd5;
	localparam logic [DIGIT_W-1:0] BCD_ADJ   = 4'd3;

	// ascii codes, kept to the six output bits
	localparam int CHAR_W = 6;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_EMIT
	} sitd_state_t;

endpackage

[rtl/core/sitd_dabble.sv]
// ----------------------------------------------------------------------------
// sitd_dabble
// One shift-add-3 step of binary to bcd conversion: every digit at five or
// above gets three added, then the word moves left by one and takes a new bit.
// ----------------------------------------------------------------------------
module sitd_dabble
	import sitd_pkg::*;
#(
	parameter int NDIG = 10
) (
	input  logic [NDIG*DIGIT_W-1:0] bcd_in,
	input  logic                    bit_in,
	output logic [NDIG*DIGIT_W-1:0] bcd_out
);

	logic [NDIG*DIGIT_W-1:0] adj;

	// per-digit correction, digits are independent
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_in[i*DIGIT_W +: DIGIT_W] >= BCD_LIMIT) begin
				adj[i*DIGIT_W +: DIGIT_W] = bcd_in[i*DIGIT_W +: DIGIT_W] + BCD_ADJ;
			end else begin
				adj[i*DIGIT_W +: DIGIT_W] = bcd_in[i*DIGIT_W +: DIGIT_W];
			end
		end
	end

	// shift in the next magnitude bit
	assign bcd_out = {adj[NDIG*DIGIT_W-2:0], bit_in};

endmodule

[rtl/core/signed_int_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Turns one signed integer into its decimal ascii text, most significant
// character first, with a leading minus for negative values.
//
// Input channel: value with in_valid / in_ready. Output channel: one word per
// character, char_out and last, with out_valid / out_ready; last marks the
// final digit of a number. Zero gives one '0'; no leading zeros, no null.
// After a word is taken the magnitude is converted to bcd one bit per cycle
// by a shared shift-add-3 step. Leading zero digits are then dropped one per
// cycle, and the sign and digits go out one per cycle while the receiver
// takes them; the bit-serial bcd loop takes most of a number's time. in_ready
// is low while a number is being worked on. A stalled receiver holds the
// current character in the output register and the sequencer waits. Reset
// returns to idle and drops any character not yet taken.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii
	import sitd_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [VALUE_BITS-1:0] value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic        [CHAR_W-1:0]     char_out,
	output logic                         last
);

	// decimal digits needed for any magnitude up to 2^(VALUE_BITS-1)
	localparam int NDIG   = (VALUE_BITS * 1233) / 4096 + 1;
	localparam int BCD_W  = NDIG * DIGIT_W;
	localparam int CNT_W  = $clog2(VALUE_BITS);
	localparam int DCNT_W = $clog2(NDIG + 1);

	sitd_state_t state_q, state_d;

	logic [VALUE_BITS-1:0] mag_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      bcd_step;
	logic [CNT_W-1:0]      cnt_q;
	logic [DCNT_W-1:0]     dcnt_q;
	logic                  neg_q;
	logic                  out_valid_q;
	logic [CHAR_W-1:0]     char_q;
	logic                  last_q;

	logic [DIGIT_W-1:0]    top_dig;
	logic                  out_free;
	logic                  in_acc;
	logic                  do_step;
	logic                  do_shift;
	logic                  ld_sign;
	logic                  ld_dig;

	assign top_dig  = bcd_q[BCD_W-1 -: DIGIT_W];
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;

	// shared bcd conversion step
	sitd_dabble #(
		.NDIG (NDIG)
	) u_dabble (
		.bcd_in  (bcd_q),
		.bit_in  (mag_q[VALUE_BITS-1]),
		.bcd_out (bcd_step)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and strobes
	always_comb begin
		state_d  = state_q;
		do_step  = 1'b0;
		do_shift = 1'b0;
		ld_sign  = 1'b0;
		ld_dig   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				do_step = 1'b1;
				if (cnt_q == CNT_W'(VALUE_BITS - 1)) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (top_dig == '0 && dcnt_q != DCNT_W'(1)) begin
					do_shift = 1'b1;
				end else if (neg_q) begin
					state_d = ST_SIGN;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_SIGN: begin
				if (out_free) begin
					ld_sign = 1'b1;
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					ld_dig   = 1'b1;
					do_shift = 1'b1;
					if (dcnt_q == DCNT_W'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// magnitude, bcd word and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			dcnt_q <= '0;
			neg_q  <= 1'b0;
		end else begin
			if (in_acc) begin
				neg_q  <= value[VALUE_BITS-1];
				cnt_q  <= '0;
				dcnt_q <= DCNT_W'(NDIG);
			end else if (do_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_shift) begin
				dcnt_q <= dcnt_q - DCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mag_q <= value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;
			bcd_q <= '0;
		end else if (do_step) begin
			mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
			bcd_q <= bcd_step;
		end else if (do_shift) begin
			bcd_q <= {bcd_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_sign || ld_dig) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_sign) begin
			char_q <= CH_MINUS;
			last_q <= 1'b0;
		end else if (ld_dig) begin
			char_q <= CH_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_dig};
			last_q <= (dcnt_q == DCNT_W'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign char_out  = char_q;
	assign last      = last_q;

endmodule
